// ===== rtl/ybd_pkg.sv =====
// ============================================================================
// ybd_pkg
// Shared types and constants for the detection-head box decoder.
// ============================================================================
package ybd_pkg;

    // Field widths fixed by the interface.
    localparam int STAGE_W  = 2;
    localparam int CHAN_W   = 7;
    localparam int LOGIT_W  = 16;
    localparam int GRID_W   = 16;
    localparam int ANCHOR_W = 16;
    localparam int STRIDE_W = 8;
    localparam int OUT_W    = 21;
    localparam int CFG_IDX_W = 2;

    // Sigmoid output, unsigned Q0.16 in the range 0..65536.
    localparam int SIG_W = 17;

    // Number of detection stages and the highest stage index in use.
    localparam int NUM_STAGES = 3;
    localparam logic [STAGE_W-1:0] STAGE_TOP =
        STAGE_W'((NUM_STAGES - 1 < 2) ? (NUM_STAGES - 1) : 2);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ONE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_TWO  = 2'd2;

    // Reset values of the stage strides.
    localparam logic [STRIDE_W-1:0] STRIDE_ZERO_RST = 8'd8;
    localparam logic [STRIDE_W-1:0] STRIDE_ONE_RST  = 8'd16;
    localparam logic [STRIDE_W-1:0] STRIDE_TWO_RST  = 8'd32;

    // Decode path chosen by the channel.
    typedef enum logic [1:0] {
        KIND_XY,
        KIND_WH,
        KIND_SCORE
    } t_kind;

endpackage

// ===== rtl/ybd_sigmoid.sv =====
// ============================================================================
// ybd_sigmoid
// Piecewise-linear logistic sigmoid: signed Q8.8 in, unsigned Q0.16 out.
// ============================================================================
module ybd_sigmoid
    import ybd_pkg::*;
(
    input  logic signed [LOGIT_W-1:0] i_logit,
    output logic        [SIG_W-1:0]   o_sig
);

    // Breakpoints on |x| in Q8.8 and the segment offsets in Q0.16.
    localparam logic [SIG_W-1:0] BRK_SAT  = 17'd1280;
    localparam logic [SIG_W-1:0] BRK_HIGH = 17'd608;
    localparam logic [SIG_W-1:0] BRK_MID  = 17'd256;
    localparam logic [SIG_W-1:0] OFS_HIGH = 17'd55296;
    localparam logic [SIG_W-1:0] OFS_MID  = 17'd40960;
    localparam logic [SIG_W-1:0] OFS_LOW  = 17'd32768;
    localparam logic [SIG_W-1:0] ONE      = 17'd65536;

    logic [SIG_W-1:0] mag;
    logic [SIG_W-1:0] pos;

    // Magnitude of the logit; the most negative code gives 32768.
    always_comb begin
        if (i_logit[LOGIT_W-1]) begin
            mag = SIG_W'(-{i_logit[LOGIT_W-1], i_logit});
        end else begin
            mag = SIG_W'({1'b0, i_logit});
        end
    end

    // Evaluate the segment for the magnitude; slopes are plain shifts.
    always_comb begin
        if (mag >= BRK_SAT) begin
            pos = ONE;
        end else if (mag >= BRK_HIGH) begin
            pos = {mag[13:0], 3'b000} + OFS_HIGH;
        end else if (mag >= BRK_MID) begin
            pos = {mag[11:0], 5'b00000} + OFS_MID;
        end else begin
            pos = {mag[10:0], 6'b000000} + OFS_LOW;
        end
    end

    // Mirror around one half for negative logits.
    assign o_sig = i_logit[LOGIT_W-1] ? (ONE - pos) : pos;

endmodule

// ===== rtl/ybd_stride_regs.sv =====
// ============================================================================
// ybd_stride_regs
// Per-stage stride registers with a write port and a stage lookup.
// ============================================================================
module ybd_stride_regs
    import ybd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [STRIDE_W-1:0]  i_cfg_data,
    input  logic [STAGE_W-1:0]   i_stage,
    output logic [STRIDE_W-1:0]  o_stride
);

    logic [STRIDE_W-1:0] r_stride_zero;
    logic [STRIDE_W-1:0] r_stride_one;
    logic [STRIDE_W-1:0] r_stride_two;
    logic [STAGE_W-1:0]  stage_clamped;

    // Register writes; an index past the last register is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride_zero <= STRIDE_ZERO_RST;
            r_stride_one  <= STRIDE_ONE_RST;
            r_stride_two  <= STRIDE_TWO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STRIDE_ZERO: r_stride_zero <= i_cfg_data;
                CFG_STRIDE_ONE:  r_stride_one  <= i_cfg_data;
                CFG_STRIDE_TWO:  r_stride_two  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage index past the last stage uses the last stage's stride.
    assign stage_clamped = (i_stage > STAGE_TOP) ? STAGE_TOP : i_stage;

    always_comb begin
        unique case (stage_clamped)
            2'd0:    o_stride = r_stride_zero;
            2'd1:    o_stride = r_stride_one;
            default: o_stride = r_stride_two;
        endcase
    end

endmodule

// ===== rtl/yolo_box_decode_core.sv =====
// ============================================================================
// yolo_box_decode_core
// Detection-head decode: sigmoid, then box offset, box size or score.
// ============================================================================
// One logit enters per clock and one decoded value leaves per clock while the
// output is not stalled; each transaction passes through four register
// stages, stage 1 to the output register in stage 4. The depth is set by the
// box-size path, which chains two registered multiplies (s*s, then times the
// anchor) ahead of the rounding and saturation stage. A stall on the output
// holds the pipeline; empty stages still fill while the output waits, so no
// bubble is kept. The user must write strides through the configuration port
// while no transaction is in flight; the block does not enforce this.
module yolo_box_decode_core
    import ybd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [STRIDE_W-1:0]         i_cfg_data,
    // Input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [STAGE_W-1:0]          i_stage_index,
    input  logic [CHAN_W-1:0]           i_channel_index,
    input  logic signed [LOGIT_W-1:0]   i_raw_logit,
    input  logic signed [GRID_W-1:0]    i_grid_offset,
    input  logic [ANCHOR_W-1:0]         i_anchor_size,
    input  logic                        i_last_in,
    // Output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [OUT_W-1:0]     o_decoded_value,
    output logic                        o_last_out
);

    localparam logic [CHAN_W-1:0] CHAN_LAST_XY = 7'd1;
    localparam logic [CHAN_W-1:0] CHAN_LAST_WH = 7'd3;
    localparam logic signed [25:0] XY_MAX = 26'sd1048575;
    localparam logic signed [25:0] XY_MIN = -26'sd1048576;
    localparam logic [22:0]        WH_MAX = 23'd1048575;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 21'sd1048575;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -21'sd1048576;

    // Stage enables: a stage loads when it is empty or its successor loads.
    logic en1, en2, en3, en4;

    // Stage 1 registers: sigmoid and operand capture.
    logic                       r1_valid;
    t_kind                      r1_kind;
    logic [SIG_W-1:0]           r1_sig;
    logic [STRIDE_W-1:0]        r1_stride;
    logic signed [GRID_W-1:0]   r1_grid;
    logic [ANCHOR_W-1:0]        r1_anchor;
    logic                       r1_last;

    // Stage 2 registers: first multiply.
    logic                       r2_valid;
    t_kind                      r2_kind;
    logic signed [33:0]         r2_xy_prod;
    logic [32:0]                r2_sq;
    logic [SIG_W-1:0]           r2_sig;
    logic [ANCHOR_W-1:0]        r2_anchor;
    logic                       r2_last;

    // Stage 3 registers: second multiply, and box-offset and score rounding.
    logic                       r3_valid;
    t_kind                      r3_kind;
    logic [48:0]                r3_wh_prod;
    logic signed [25:0]         r3_xy;
    logic [8:0]                 r3_score;
    logic                       r3_last;

    // Stage 4 registers: output.
    logic                       r4_valid;
    t_kind                      r4_kind;
    logic signed [OUT_W-1:0]    r4_value;
    logic                       r4_last;

    logic [SIG_W-1:0]           sig;
    logic [STRIDE_W-1:0]        stride;
    t_kind                      in_kind;
    logic signed [24:0]         xy_sum;
    logic signed [33:0]         xy_prod;
    logic [33:0]                sq_full;
    logic signed [33:0]         xy_rnd;
    logic [SIG_W-1:0]           score_rnd;
    logic [48:0]                wh_rnd;
    logic [22:0]                wh_q;
    logic signed [OUT_W-1:0]    n_value;

    assign en4 = !r4_valid || !i_stall;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign o_stall = !en1;

    ybd_sigmoid u_sigmoid (
        .i_logit (i_raw_logit),
        .o_sig   (sig)
    );

    ybd_stride_regs u_stride_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stage     (i_stage_index),
        .o_stride    (stride)
    );

    // Channel decode: box offset, box size, or a plain score.
    always_comb begin
        if (i_channel_index <= CHAN_LAST_XY) begin
            in_kind = KIND_XY;
        end else if (i_channel_index <= CHAN_LAST_WH) begin
            in_kind = KIND_WH;
        end else begin
            in_kind = KIND_SCORE;
        end
    end

    // Stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_kind   <= in_kind;
            r1_sig    <= sig;
            r1_stride <= stride;
            r1_grid   <= i_grid_offset;
            r1_anchor <= i_anchor_size;
            r1_last   <= i_last_in;
        end
    end

    // Stage 2: (2s + grid) * stride in Q.16, and s*s in Q.32.
    assign xy_sum  = $signed({7'b0, r1_sig, 1'b0})
                   + $signed({r1_grid[GRID_W-1], r1_grid, 8'b0});
    assign xy_prod = 34'(xy_sum * $signed({1'b0, r1_stride}));
    assign sq_full = r1_sig * r1_sig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_kind    <= r1_kind;
            r2_xy_prod <= xy_prod;
            r2_sq      <= sq_full[32:0];
            r2_sig     <= r1_sig;
            r2_anchor  <= r1_anchor;
            r2_last    <= r1_last;
        end
    end

    // Stage 3: s*s*anchor, and round the offset and score to Q.8.
    assign xy_rnd    = r2_xy_prod + 34'sd128;
    assign score_rnd = r2_sig + 17'd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_kind    <= r2_kind;
            r3_wh_prod <= 49'(r2_sq * r2_anchor);
            r3_xy      <= xy_rnd[33:8];
            r3_score   <= score_rnd[16:8];
            r3_last    <= r2_last;
        end
    end

    // Stage 4: (2s)^2 * anchor is 4*s*s*anchor in Q.36, so shift by 26; saturate.
    assign wh_rnd = r3_wh_prod + 49'd33554432;
    assign wh_q   = wh_rnd[48:26];

    always_comb begin
        case (r3_kind)
            KIND_XY: begin
                if (r3_xy > XY_MAX) begin
                    n_value = OUT_MAX;
                end else if (r3_xy < XY_MIN) begin
                    n_value = OUT_MIN;
                end else begin
                    n_value = r3_xy[OUT_W-1:0];
                end
            end
            KIND_WH: begin
                if (wh_q > WH_MAX) begin
                    n_value = OUT_MAX;
                end else begin
                    n_value = $signed(wh_q[OUT_W-1:0]);
                end
            end
            default: begin
                n_value = $signed({12'b0, r3_score});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en4) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_kind  <= r3_kind;
            r4_value <= n_value;
            r4_last  <= r3_last;
        end
    end

    assign o_valid         = r4_valid;
    assign o_decoded_value = r4_value;
    assign o_last_out      = r4_last;

    // Upstream is held off only when every stage is full and the output waits.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r1_valid && r2_valid && r3_valid && r4_valid && i_stall))
        else $error("input stalled while the pipeline has room");

    // A transaction in stage 3 moves to the output whenever the output frees.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && en4) |=> r4_valid)
        else $error("transaction lost between stage 3 and the output");

    // Scores are probabilities: 0 to 1.0 in Q.8.
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && r4_kind == KIND_SCORE) |->
        (!r4_value[OUT_W-1] && r4_value <= 21'sd256))
        else $error("score outside zero to one");

    // Box sizes never come out negative.
    a_size_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && r4_kind == KIND_WH) |-> !r4_value[OUT_W-1])
        else $error("negative box size");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the detection-head box decoder.
// ============================================================================
// Each accepted input transaction is decoded by a bit-accurate predictor that
// runs alongside the pipeline. The predictor covers the piecewise sigmoid, the
// box offset, box size and score paths, rounding and saturation. A small
// scoreboard queues the expected results and compares every accepted output
// against the oldest one. The bench starts with a directed set of corner cases
// and then runs random traffic under several stride settings. Random idle
// cycles are applied on both sides, and twice a long output stall is applied.
// ============================================================================
module tb_top;
    import ybd_pkg::*;

    // Channel codes within a detection row.
    localparam logic [CHAN_W-1:0] CH_X      = 7'd0;
    localparam logic [CHAN_W-1:0] CH_Y      = 7'd1;
    localparam logic [CHAN_W-1:0] CH_W      = 7'd2;
    localparam logic [CHAN_W-1:0] CH_H      = 7'd3;
    localparam logic [CHAN_W-1:0] CH_OBJ    = 7'd4;
    localparam logic [CHAN_W-1:0] CH_CLASS0 = 7'd5;
    localparam logic [CHAN_W-1:0] CHAN_MAX  = 7'd127;
    localparam int                MAX_CLASSES = 80;

    // Register index that has no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Output range of the signed Q12.8 result.
    localparam longint OUT_HI = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint OUT_LO = -(longint'(1) << (OUT_W - 1));

    localparam int PHASES        = 7;
    localparam int ITEMS_PER_SET = 250;

    typedef struct packed {
        logic [STAGE_W-1:0]         stage;
        logic [CHAN_W-1:0]          chan;
        logic signed [LOGIT_W-1:0]  logit;
        logic signed [GRID_W-1:0]   grid;
        logic [ANCHOR_W-1:0]        anchor;
        logic                       last;
    } t_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    last;
    } t_decoded;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the stride registers, predicts each decoded value
    // and checks the outputs in order.
    // ------------------------------------------------------------------------
    class decode_scoreboard;
        logic [STRIDE_W-1:0] stride_q[3];
        t_decoded            expected_q[$];
        int                  errors;

        function new();
            stride_q[0] = STRIDE_ZERO_RST;
            stride_q[1] = STRIDE_ONE_RST;
            stride_q[2] = STRIDE_TWO_RST;
            errors      = 0;
        endfunction

        // Writes to an index without a register are dropped by the block.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STRIDE_W-1:0] val);
            if (idx == CFG_STRIDE_ZERO)
                stride_q[0] = val;
            else if (idx == CFG_STRIDE_ONE)
                stride_q[1] = val;
            else if (idx == CFG_STRIDE_TWO)
                stride_q[2] = val;
        endfunction

        function logic signed [OUT_W-1:0] decode_value(t_item it);
            longint              mag;
            longint              sig;
            longint              acc;
            longint              res;
            t_kind               kind;
            logic [STAGE_W-1:0]  stg;

            // Piecewise sigmoid in unsigned Q0.16, mirrored for negative logits.
            mag = (it.logit < 0) ? -longint'(it.logit) : longint'(it.logit);
            if (mag >= 1280)
                sig = 65536;
            else if (mag >= 608)
                sig = 8 * mag + 55296;
            else if (mag >= 256)
                sig = 32 * mag + 40960;
            else
                sig = 64 * mag + 32768;
            if (it.logit < 0)
                sig = 65536 - sig;

            if (it.chan <= CH_Y)
                kind = KIND_XY;
            else if (it.chan <= CH_H)
                kind = KIND_WH;
            else
                kind = KIND_SCORE;

            // Stages past the last one use the stride of the last one.
            stg = (it.stage > STAGE_TOP) ? STAGE_TOP : it.stage;

            // Each path rounds half up on its final shift to Q.8.
            case (kind)
                KIND_XY: begin
                    acc = (2 * sig + longint'(it.grid) * 256) * longint'(stride_q[stg]);
                    res = (acc + 128) >>> 8;
                end
                KIND_WH: begin
                    acc = (2 * sig) * (2 * sig) * longint'(it.anchor);
                    res = (acc + (longint'(1) << 27)) >>> 28;
                end
                default: begin
                    res = (sig + 128) >>> 8;
                end
            endcase

            if (res > OUT_HI)
                res = OUT_HI;
            else if (res < OUT_LO)
                res = OUT_LO;
            return res[OUT_W-1:0];
        endfunction

        function void note_input(t_item it);
            t_decoded exp_res;
            exp_res.value = decode_value(it);
            exp_res.last  = it.last;
            expected_q = {expected_q, exp_res};
        endfunction

        function void check_result(logic signed [OUT_W-1:0] value, logic last);
            t_decoded exp_res;
            if (expected_q.size() == 0) begin
                $error("decoded_value: no result expected, got %0d", value);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (value !== exp_res.value) begin
                $error("decoded_value: expected %0d, got %0d", exp_res.value, value);
                errors++;
            end
            if (last !== exp_res.last) begin
                $error("last_out: expected %0b, got %0b", exp_res.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [STRIDE_W-1:0]        i_cfg_data;
    logic                       i_valid;
    logic                       o_stall;
    logic [STAGE_W-1:0]         i_stage_index;
    logic [CHAN_W-1:0]          i_channel_index;
    logic signed [LOGIT_W-1:0]  i_raw_logit;
    logic signed [GRID_W-1:0]   i_grid_offset;
    logic [ANCHOR_W-1:0]        i_anchor_size;
    logic                       i_last_in;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [OUT_W-1:0]    o_decoded_value;
    logic                       o_last_out;

    decode_scoreboard sb;
    int               send_burst = 0;
    int               recv_burst = 0;

    yolo_box_decode_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_stage_index   (i_stage_index),
        .i_channel_index (i_channel_index),
        .i_raw_logit     (i_raw_logit),
        .i_grid_offset   (i_grid_offset),
        .i_anchor_size   (i_anchor_size),
        .i_last_in       (i_last_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_decoded_value (o_decoded_value),
        .o_last_out      (o_last_out)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle count per transaction, with occasional back-to-back stretches.
    function automatic int draw_wait(inout int burst_left);
        int n;
        if (burst_left > 0) begin
            burst_left--;
            n = 0;
        end else if ($urandom_range(0, 31) == 0) begin
            burst_left = $urandom_range(10, 40);
            n = 0;
        end else begin
            n = $urandom_range(0, 10);
        end
        return n;
    endfunction

    function automatic t_item mk(int stage, int chan, int logit, int grid, int anchor,
                                 int last);
        t_item it;
        it.stage  = stage[STAGE_W-1:0];
        it.chan   = chan[CHAN_W-1:0];
        it.logit  = logit[LOGIT_W-1:0];
        it.grid   = grid[GRID_W-1:0];
        it.anchor = anchor[ANCHOR_W-1:0];
        it.last   = last[0];
        return it;
    endfunction

    // Random transaction biased toward the box channels and the sigmoid knees.
    function automatic t_item random_item();
        t_item it;
        int    sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            it.chan = CHAN_W'($urandom_range(CH_X, CH_Y));
        else if (sel < 6)
            it.chan = CHAN_W'($urandom_range(CH_W, CH_H));
        else
            it.chan = CHAN_W'($urandom_range(CH_OBJ, CHAN_MAX));
        it.stage = STAGE_W'($urandom_range(0, 3));
        if ($urandom_range(0, 1))
            it.logit = LOGIT_W'($urandom);
        else
            it.logit = LOGIT_W'($urandom_range(0, 2800) - 1400);
        if ($urandom_range(0, 1))
            it.grid = GRID_W'($urandom);
        else
            it.grid = GRID_W'($urandom_range(0, 80 * 256));
        if ($urandom_range(0, 1))
            it.anchor = ANCHOR_W'($urandom);
        else
            it.anchor = ANCHOR_W'($urandom_range(0, 4095));
        it.last = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic send_item(input t_item it);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_stage_index   <= it.stage;
        i_channel_index <= it.chan;
        i_raw_logit     <= it.logit;
        i_grid_offset   <= it.grid;
        i_anchor_size   <= it.anchor;
        i_last_in       <= it.last;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(it);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write all three strides plus one write to the unused index.
    task automatic program_strides(input logic [STRIDE_W-1:0] s0,
                                   input logic [STRIDE_W-1:0] s1,
                                   input logic [STRIDE_W-1:0] s2,
                                   input logic [STRIDE_W-1:0] junk);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [STRIDE_W-1:0]  val[4];
        idx = '{CFG_STRIDE_ZERO, CFG_STRIDE_ONE, CFG_STRIDE_TWO, CFG_UNUSED};
        val = '{s0, s1, s2, junk};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            sb.write_reg(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Check every accepted output transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_decoded_value, o_last_out);
    end

    // Output side: random stalls, with two long hold-offs to back up the pipe.
    initial begin
        int n;
        int results_taken;
        results_taken = 0;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (results_taken == 300 || results_taken == 1100)
                n = 250;
            else
                n = draw_wait(recv_burst);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            results_taken++;
        end
    end

    // Run-time limit.
    initial begin
        #2_000_000;
        $display("[yolo_box_decode_core] ERROR");
        $finish;
    end

    // Main sequence: reset, directed corners, then random traffic per stride set.
    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_STRIDE_ZERO;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_stage_index   <= '0;
        i_channel_index <= CH_X;
        i_raw_logit     <= '0;
        i_grid_offset   <= '0;
        i_anchor_size   <= '0;
        i_last_in       <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners under the reset strides.
        send_item(mk(0, CH_X, 0, 0, 0, 0));
        send_item(mk(2, CH_X, 32767, 32767, 0, 0));            // saturates high
        send_item(mk(2, CH_Y, -32768, -32768, 0, 0));          // saturates low
        send_item(mk(3, CH_X, 255, 1000, 0, 0));               // stage clamped
        send_item(mk(0, CH_W, 32767, 0, 65535, 0));           // largest box size
        send_item(mk(1, CH_H, -32768, 0, 65535, 0));
        send_item(mk(2, CH_W, 1280, 0, 1234, 0));
        send_item(mk(0, CH_H, 1279, 0, 16, 0));
        send_item(mk(1, CH_OBJ, 608, 0, 0, 0));
        send_item(mk(1, CH_OBJ, 607, 0, 0, 0));
        send_item(mk(0, CH_CLASS0, 256, 0, 0, 0));
        send_item(mk(0, CH_CLASS0, 255, 0, 0, 0));
        send_item(mk(2, CH_CLASS0 + MAX_CLASSES - 1, -256, 0, 0, 0));
        send_item(mk(2, CH_CLASS0 + MAX_CLASSES, -1280, 0, 0, 0)); // past class range
        send_item(mk(3, CHAN_MAX, -1, 0, 0, 0));
        send_item(mk(1, CH_OBJ, -608, 32767, 65535, 1));      // unused inputs set
        send_item(mk(1, CH_X, -607, -1, 65535, 0));
        send_item(mk(3, CH_W, 1, -32768, 1, 0));
        send_item(mk(0, CH_Y, -255, 256, 0, 1));
        send_item(mk(0, CH_H, 0, 0, 32768, 1));

        // Random traffic; strides change only while the pipe is empty.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                i_valid <= 1'b0;
                wait_drained();
                case (phase)
                    1: program_strides(8'd1, 8'd1, 8'd1, 8'd255);
                    2: program_strides(8'd128, 8'd128, 8'd128, 8'd0);
                    3: program_strides(8'd255, 8'd0, 8'd170, 8'd85);   // zero stride
                    4: program_strides(8'd85, 8'd255, 8'd0, 8'd170);
                    default: program_strides(STRIDE_W'($urandom_range(1, 128)),
                                             STRIDE_W'($urandom_range(1, 128)),
                                             STRIDE_W'($urandom_range(1, 128)),
                                             STRIDE_W'($urandom));
                endcase
            end
            repeat (ITEMS_PER_SET) send_item(random_item());
        end
        i_valid <= 1'b0;

        // Drain and let any stray output show up.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[yolo_box_decode_core] OK");
        else
            $display("[yolo_box_decode_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ybd_pkg.sv
rtl/ybd_sigmoid.sv
rtl/ybd_stride_regs.sv
rtl/yolo_box_decode_core.sv
sim/tb_top.sv
